// File: design/mrpc_pkg.sv
// Package for the multi relay pulse controller.
// Command codes, register indexes, widths and the relay slot control and status types.
// No dependencies.
package mrpc_pkg;

    localparam int RELAY_SLOTS  = 8;
    localparam int CMD_W        = 3;
    localparam int ID_W         = 4;
    localparam int REV_W        = 32;
    localparam int PULSE_W      = 16;
    localparam int CNT_W        = 4;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 64;

    localparam logic [CMD_W-1:0] CMD_TICK  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ON    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_OFF   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_PULSE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_STORE = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_RELAY_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LOW  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_LO    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_HI    = 3'd4;

    localparam logic [PULSE_W-1:0] DEFAULT_PULSE     = 16'd250;
    localparam logic [CNT_W-1:0]   RELAY_COUNT_RESET = 4'd8;

    typedef struct packed {
        logic               tick;
        logic               in_range;
        logic               enabled;
        logic               apply;
        logic               op_on;
        logic               op_off;
        logic               op_pulse;
        logic               store_rev;
        logic [REV_W-1:0]   rev;
        logic [PULSE_W-1:0] pulse_len;
    } t_relay_ctl;

    typedef struct packed {
        logic on_next;
        logic expired;
        logic rev_match;
    } t_relay_sts;

endpackage

// File: design/multi_relay_pulse_controller.sv
// Multi relay pulse controller top level: input register, command decode, relay slots,
// result register and configuration registers. Depends on mrpc_pkg and mrpc_relay.
//
// Each beat on the input channel is a 1 ms tick or a command for one relay and yields exactly
// one result beat. The block takes one beat per clock unless the consumer holds off the output
// register: a beat is captured in the input register and, when it advances, the relay slots
// update their state in one pass of short logic as the result lands in the output register.
// The input side keeps accepting while a result waits for the consumer, until both registers
// are full.
// Configuration writes take effect at once and are meant to happen while the block is idle.
module multi_relay_pulse_controller
    import mrpc_pkg::*;
#(
    parameter int NUM_RELAYS = RELAY_SLOTS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [CMD_W-1:0]       i_command,
    input  logic [ID_W-1:0]        i_relay_id,
    input  logic [REV_W-1:0]       i_revision,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [RELAY_SLOTS-1:0] o_pin_levels,
    output logic [RELAY_SLOTS-1:0] o_relay_on_mask,
    output logic                   o_accepted,
    output logic [RELAY_SLOTS-1:0] o_expired_mask,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    // configuration
    logic [CNT_W-1:0]       r_relay_count;
    logic [RELAY_SLOTS-1:0] r_enable;
    logic [RELAY_SLOTS-1:0] r_active_low;
    logic [CFG_DATA_W-1:0]  r_pulse_lo;
    logic [CFG_DATA_W-1:0]  r_pulse_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_relay_count <= RELAY_COUNT_RESET;
            r_enable      <= '0;
            r_active_low  <= '0;
            r_pulse_lo    <= '0;
            r_pulse_hi    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_RELAY_COUNT: r_relay_count <= i_cfg_data[CNT_W-1:0];
                REG_ENABLE:      r_enable      <= i_cfg_data[RELAY_SLOTS-1:0];
                REG_ACTIVE_LOW:  r_active_low  <= i_cfg_data[RELAY_SLOTS-1:0];
                REG_PULSE_LO:    r_pulse_lo    <= i_cfg_data;
                REG_PULSE_HI:    r_pulse_hi    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline control
    logic             r_in_vld;
    logic [CMD_W-1:0] r_cmd;
    logic [ID_W-1:0]  r_id;
    logic [REV_W-1:0] r_rev;
    logic             r_out_vld;
    logic             w_adv;

    assign w_adv      = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_cmd <= i_command;
            r_id  <= i_relay_id;
            r_rev <= i_revision;
        end
    end

    // decode
    logic [CNT_W-1:0]       w_cnt;
    logic [ID_W-1:0]        w_k;
    logic                   w_id_ok;
    logic                   w_is_cmd;
    logic                   w_dup;
    logic                   w_acc;
    logic [RELAY_SLOTS-1:0] w_match;
    logic [RELAY_SLOTS-1:0] w_on;
    logic [RELAY_SLOTS-1:0] w_exp;
    logic [RELAY_SLOTS-1:0] w_range;
    logic [RELAY_SLOTS-1:0] w_pins;

    assign w_cnt    = (r_relay_count < CNT_W'(NUM_RELAYS)) ? r_relay_count : CNT_W'(NUM_RELAYS);
    assign w_k      = r_id - 1'b1;
    assign w_id_ok  = (r_id != '0) && (r_id <= w_cnt) && r_enable[w_k[2:0]];
    assign w_is_cmd = (r_cmd != CMD_TICK) && (r_cmd != CMD_STORE);
    assign w_dup    = (r_rev != '0) && w_match[w_k[2:0]];
    assign w_acc    = w_is_cmd && w_id_ok && !w_dup;

    for (genvar i = 0; i < RELAY_SLOTS; i++) begin : g_slot
        assign w_range[i] = (CNT_W'(i) < w_cnt);
        if (i < NUM_RELAYS) begin : g_used
            localparam int SH = PULSE_W * (i % 4);
            t_relay_ctl         w_ctl;
            t_relay_sts         w_sts;
            logic               w_sel;
            logic [PULSE_W-1:0] w_dur;

            assign w_sel = (r_id == ID_W'(i + 1));
            assign w_dur = (i < 4) ? r_pulse_lo[SH +: PULSE_W] : r_pulse_hi[SH +: PULSE_W];

            assign w_ctl.tick      = (r_cmd == CMD_TICK);
            assign w_ctl.in_range  = w_range[i];
            assign w_ctl.enabled   = r_enable[i];
            assign w_ctl.apply     = w_sel && w_acc;
            assign w_ctl.op_on     = (r_cmd == CMD_ON);
            assign w_ctl.op_off    = (r_cmd == CMD_OFF);
            assign w_ctl.op_pulse  = (r_cmd == CMD_PULSE);
            assign w_ctl.store_rev = w_sel && (r_rev != '0) && ((r_cmd == CMD_STORE) || w_acc);
            assign w_ctl.rev       = r_rev;
            assign w_ctl.pulse_len = (w_dur != '0) ? w_dur : DEFAULT_PULSE;

            mrpc_relay u_relay (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_step  (w_adv),
                .i_ctl   (w_ctl),
                .o_sts   (w_sts)
            );

            assign w_on[i]    = w_sts.on_next;
            assign w_exp[i]   = w_sts.expired;
            assign w_match[i] = w_sts.rev_match;
        end else begin : g_unused
            assign w_on[i]    = 1'b0;
            assign w_exp[i]   = 1'b0;
            assign w_match[i] = 1'b0;
        end
    end

    assign w_pins = (w_on ^ r_active_low) & r_enable & w_range;

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    logic [RELAY_SLOTS-1:0] r_pins;
    logic [RELAY_SLOTS-1:0] r_on;
    logic                   r_acc;
    logic [RELAY_SLOTS-1:0] r_exp;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_pins <= w_pins;
            r_on   <= w_on;
            r_acc  <= w_acc;
            r_exp  <= w_exp;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_pin_levels    = r_pins;
    assign o_relay_on_mask = r_on;
    assign o_accepted      = r_acc;
    assign o_expired_mask  = r_exp;

    // checks
    a_acc_exp_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> !(r_acc && (r_exp != '0)))
        else $error("accepted and expired in one beat");

    a_adv_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> r_out_vld)
        else $error("advanced beat lost");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_vld |-> o_in_ready)
        else $error("input stalled with empty output");

    a_exp_tick_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && (r_cmd != CMD_TICK)) |-> (w_exp == '0))
        else $error("expiry outside a tick");

endmodule

// File: design/mrpc_relay.sv
// One relay slot: on state, pulse countdown and last revision tag.
// Depends on mrpc_pkg.
module mrpc_relay
    import mrpc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  t_relay_ctl i_ctl,
    output t_relay_sts o_sts
);

    logic               r_on;
    logic [PULSE_W-1:0] r_rem;
    logic [REV_W-1:0]   r_rev;
    logic               n_on;
    logic [PULSE_W-1:0] n_rem;
    logic [REV_W-1:0]   n_rev;
    logic               w_expired;

    always_comb begin
        n_on      = r_on;
        n_rem     = r_rem;
        n_rev     = r_rev;
        w_expired = 1'b0;
        if (i_ctl.tick && i_ctl.in_range && (r_rem != '0)) begin
            n_rem = r_rem - 1'b1;
            if (r_rem == PULSE_W'(1)) begin
                w_expired = 1'b1;
                if (i_ctl.enabled) begin
                    n_on = 1'b0;
                end
            end
        end
        if (i_ctl.store_rev) begin
            n_rev = i_ctl.rev;
        end
        if (i_ctl.apply) begin
            if (i_ctl.op_on) begin
                n_rem = '0;
                n_on  = 1'b1;
            end else if (i_ctl.op_off) begin
                n_rem = '0;
                n_on  = 1'b0;
            end else if (i_ctl.op_pulse) begin
                n_rem = i_ctl.pulse_len;
                n_on  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on  <= 1'b0;
            r_rem <= '0;
            r_rev <= '0;
        end else if (i_step) begin
            r_on  <= n_on;
            r_rem <= n_rem;
            r_rev <= n_rev;
        end
    end

    assign o_sts.on_next   = n_on;
    assign o_sts.expired   = w_expired;
    assign o_sts.rev_match = (r_rev == i_ctl.rev);

endmodule

// File: dv/multi_relay_pulse_controller_test.sv
// Testbench for multi_relay_pulse_controller: directed and random beats checked against
// a local relay predictor, with random input gaps and output stalls.
// Depends on mrpc_pkg and the multi_relay_pulse_controller RTL.
`timescale 1ns / 1ps

module multi_relay_pulse_controller_test;
    import mrpc_pkg::*;

    localparam logic [CMD_W-1:0]     CMD_RSVD5 = 3'd5;
    localparam logic [CMD_W-1:0]     CMD_RSVD7 = 3'd7;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
    localparam int DRAIN_CYCLES = 6;
    localparam int HOLD_CYCLES  = 80;
    localparam int CYCLE_LIMIT  = 500000;

    typedef struct packed {
        logic [RELAY_SLOTS-1:0] pins;
        logic [RELAY_SLOTS-1:0] on_mask;
        logic                   acc;
        logic [RELAY_SLOTS-1:0] expired;
    } t_relay_result;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SLOW, RX_PATTERN} t_rx_mode;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_ready;
    logic [CMD_W-1:0]       i_command = CMD_TICK;
    logic [ID_W-1:0]        i_relay_id = '0;
    logic [REV_W-1:0]       i_revision = '0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    logic [RELAY_SLOTS-1:0] o_pin_levels;
    logic [RELAY_SLOTS-1:0] o_relay_on_mask;
    logic                   o_accepted;
    logic [RELAY_SLOTS-1:0] o_expired_mask;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx = REG_RELAY_COUNT;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    multi_relay_pulse_controller uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_command       (i_command),
        .i_relay_id      (i_relay_id),
        .i_revision      (i_revision),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_pin_levels    (o_pin_levels),
        .o_relay_on_mask (o_relay_on_mask),
        .o_accepted      (o_accepted),
        .o_expired_mask  (o_expired_mask),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    // predictor state and register copies
    logic [CNT_W-1:0]       cfg_count      = RELAY_COUNT_RESET;
    logic [RELAY_SLOTS-1:0] cfg_enable     = '0;
    logic [RELAY_SLOTS-1:0] cfg_active_low = '0;
    logic [CFG_DATA_W-1:0]  cfg_pulse_lo   = '0;
    logic [CFG_DATA_W-1:0]  cfg_pulse_hi   = '0;
    logic                   relay_state [RELAY_SLOTS] = '{default: 1'b0};
    logic [PULSE_W-1:0]     pulse_left  [RELAY_SLOTS] = '{default: '0};
    logic [REV_W-1:0]       last_tag    [RELAY_SLOTS] = '{default: '0};

    t_relay_result pending_results [$];

    int errors = 0;
    int beats_sent = 0;
    int results_checked = 0;
    int ticks_sent = 0;
    int accepted_cmds = 0;
    int expiries = 0;
    int settings_applied = 0;
    bit sender_gaps = 1'b1;
    int burst_left = 0;
    bit hold_req = 1'b0;
    int hold_left = 0;
    t_rx_mode rx_mode = RX_OPEN;
    int rx_mode_left = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("%0t: timeout, %0d results still expected", $time, pending_results.size());
        $display("multi_relay_pulse_controller_test NOT OK");
        $finish;
    end

    function automatic int active_count();
        return (cfg_count < RELAY_SLOTS) ? int'(cfg_count) : RELAY_SLOTS;
    endfunction

    function automatic logic [PULSE_W-1:0] pulse_duration(int k);
        logic [CFG_DATA_W-1:0] word;
        logic [PULSE_W-1:0]    d;
        word = (k < 4) ? cfg_pulse_lo : cfg_pulse_hi;
        d = word[PULSE_W*(k%4) +: PULSE_W];
        return (d == '0) ? DEFAULT_PULSE : d;
    endfunction

    function automatic t_relay_result predict_relays(logic [CMD_W-1:0] cmd,
                                                     logic [ID_W-1:0] id,
                                                     logic [REV_W-1:0] rev);
        t_relay_result r;
        int n;
        int k;
        r = '0;
        n = active_count();
        if (cmd == CMD_TICK) begin
            for (int i = 0; i < n; i++) begin
                if (pulse_left[i] != '0) begin
                    pulse_left[i]--;
                    if (pulse_left[i] == '0) begin
                        r.expired[i] = 1'b1;
                        if (cfg_enable[i]) relay_state[i] = 1'b0;
                    end
                end
            end
        end else if (cmd == CMD_STORE) begin
            if (id >= 1 && id <= RELAY_SLOTS && rev != '0) last_tag[id-1] = rev;
        end else if (id >= 1 && id <= n && cfg_enable[id-1]) begin
            k = id - 1;
            if (!(rev != '0 && last_tag[k] == rev)) begin
                if (rev != '0) last_tag[k] = rev;
                r.acc = 1'b1;
                case (cmd)
                    CMD_ON: begin
                        pulse_left[k] = '0;
                        relay_state[k] = 1'b1;
                    end
                    CMD_OFF: begin
                        pulse_left[k] = '0;
                        relay_state[k] = 1'b0;
                    end
                    CMD_PULSE: begin
                        relay_state[k] = 1'b1;
                        pulse_left[k] = pulse_duration(k);
                    end
                    default: ;
                endcase
            end
        end
        for (int i = 0; i < RELAY_SLOTS; i++) begin
            r.on_mask[i] = relay_state[i];
            if (i < n && cfg_enable[i]) r.pins[i] = relay_state[i] ^ cfg_active_low[i];
        end
        return r;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] short_pulses();
        logic [CFG_DATA_W-1:0] w;
        for (int j = 0; j < 4; j++) w[PULSE_W*j +: PULSE_W] = PULSE_W'($urandom_range(0, 5));
        return w;
    endfunction

    // receiver stall pattern, with a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (rx_mode_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_mode_left = $urandom_range(20, 120);
        end else begin
            rx_mode_left--;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_OPEN:  i_out_ready <= 1'b1;
                RX_COIN:  i_out_ready <= 1'($urandom_range(0, 1));
                RX_SLOW:  i_out_ready <= ($urandom_range(0, 3) == 0);
                default:  i_out_ready <= (rx_mode_left % 3 != 0);
            endcase
        end
    end

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch on result %0d: expected %02h, actual %02h",
                     $time, name, results_checked, want, got);
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_relay_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat: expected none, actual %02h %02h %0b %02h",
                         $time, o_pin_levels, o_relay_on_mask, o_accepted, o_expired_mask);
            end else begin
                want = pending_results.pop_front();
                compare_field("pin_levels", want.pins, o_pin_levels);
                compare_field("relay_on_mask", want.on_mask, o_relay_on_mask);
                compare_field("accepted", {7'd0, want.acc}, {7'd0, o_accepted});
                compare_field("expired_mask", want.expired, o_expired_mask);
            end
            results_checked++;
        end
    end

    task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                             input logic [REV_W-1:0] rev);
        t_relay_result want;
        int gap;
        gap = 0;
        if (sender_gaps) begin
            if (burst_left == 0) begin
                gap = $urandom_range(1, 7);
                burst_left = $urandom_range(1, 16);
            end
            burst_left--;
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command  <= cmd;
        i_relay_id <= id;
        i_revision <= rev;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        want = predict_relays(cmd, id, rev);
        pending_results.insert(pending_results.size(), want);
        beats_sent++;
        if (cmd == CMD_TICK) ticks_sent++;
        accepted_cmds += want.acc;
        expiries += $countones(want.expired);
    endtask

    task automatic drain_block();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            REG_RELAY_COUNT: cfg_count      = data[CNT_W-1:0];
            REG_ENABLE:      cfg_enable     = data[RELAY_SLOTS-1:0];
            REG_ACTIVE_LOW:  cfg_active_low = data[RELAY_SLOTS-1:0];
            REG_PULSE_LO:    cfg_pulse_lo   = data;
            REG_PULSE_HI:    cfg_pulse_hi   = data;
            default: ;
        endcase
    endtask

    // upper bits of the narrow registers carry random junk
    task automatic configure(input logic [CNT_W-1:0] count, input logic [7:0] en,
                             input logic [7:0] al, input logic [63:0] lo, input logic [63:0] hi);
        logic [CFG_DATA_W-1:0] d;
        d = {$urandom, $urandom};
        d[CNT_W-1:0] = count;
        write_reg(REG_RELAY_COUNT, d);
        d = {$urandom, $urandom};
        d[7:0] = en;
        write_reg(REG_ENABLE, d);
        d = {$urandom, $urandom};
        d[7:0] = al;
        write_reg(REG_ACTIVE_LOW, d);
        write_reg(REG_PULSE_LO, lo);
        write_reg(REG_PULSE_HI, hi);
        write_reg(REG_SPARE, {$urandom, $urandom});
        i_cfg_we <= 1'b0;
        settings_applied++;
    endtask

    task automatic random_beat(input int tick_pct);
        logic [CMD_W-1:0] cmd;
        logic [ID_W-1:0]  id;
        logic [REV_W-1:0] rev;
        int n;
        int pick;
        n = active_count();
        pick = $urandom_range(0, 99);
        if (pick < tick_pct) begin
            cmd = CMD_TICK;
        end else begin
            pick = $urandom_range(0, 19);
            if (pick < 5)       cmd = CMD_ON;
            else if (pick < 9)  cmd = CMD_OFF;
            else if (pick < 16) cmd = CMD_PULSE;
            else if (pick < 18) cmd = CMD_STORE;
            else                cmd = CMD_W'($urandom_range(CMD_RSVD5, CMD_RSVD7));
        end
        if ($urandom_range(0, 9) < 8) id = ID_W'($urandom_range(1, (n > 0) ? n : 1));
        else                          id = ID_W'($urandom_range(0, 15));
        pick = $urandom_range(0, 9);
        if (pick < 4)                                          rev = '0;
        else if (pick < 7)                                     rev = REV_W'($urandom_range(1, 6));
        else if (pick < 8 && id >= 1 && id <= RELAY_SLOTS)     rev = last_tag[id-1];
        else                                                   rev = $urandom;
        send_beat(cmd, id, rev);
    endtask

    task automatic test_directed();
        configure(4'd8, 8'hFF, 8'h0F, {16'd1, 16'hFFFF, 16'd0, 16'd3},
                  {16'd2, 16'd0, 16'd5, 16'd1});
        send_beat(CMD_ON,    4'd1,  32'h0);
        send_beat(CMD_OFF,   4'd1,  32'h0);
        send_beat(CMD_PULSE, 4'd4,  32'h0);
        send_beat(CMD_TICK,  4'd0,  32'h0);
        send_beat(CMD_PULSE, 4'd1,  32'h1);
        send_beat(CMD_PULSE, 4'd1,  32'h1);
        send_beat(CMD_STORE, 4'd8,  32'hFFFF_FFFF);
        send_beat(CMD_ON,    4'd8,  32'hFFFF_FFFF);
        send_beat(CMD_ON,    4'd8,  32'h8000_0001);
        send_beat(CMD_ON,    4'd0,  32'h0);
        send_beat(CMD_ON,    4'd15, 32'h0);
        send_beat(CMD_STORE, 4'd9,  32'h5);
        send_beat(CMD_STORE, 4'd0,  32'h5);
        send_beat(CMD_STORE, 4'd2,  32'h0);
        send_beat(CMD_RSVD5, 4'd2,  32'h7);
        send_beat(CMD_W'(CMD_RSVD5 + 1), 4'd2, 32'h7);
        send_beat(CMD_RSVD7, 4'd3,  32'h0);
        send_beat(CMD_PULSE, 4'd2,  32'h0);
        send_beat(CMD_PULSE, 4'd3,  32'h0);
        send_beat(CMD_ON,    4'd1,  32'h0);
        send_beat(CMD_TICK,  4'd15, 32'hFFFF_FFFF);
        send_beat(CMD_TICK,  4'd0,  32'h0);
        send_beat(CMD_TICK,  4'd0,  32'h0);
        send_beat(CMD_OFF,   4'd8,  32'h2);
        send_beat(CMD_PULSE, 4'd5,  32'h3);
        drain_block();
    endtask

    // pulse runs out on a relay that was disabled meanwhile; relay beyond count is frozen
    task automatic test_disabled_expiry();
        configure(4'd8, 8'hFF, 8'hFF, 64'd0, {16'd0, 16'd1, 16'd0, 16'd2});
        send_beat(CMD_PULSE, 4'd5, 32'h0);
        send_beat(CMD_PULSE, 4'd7, 32'h0);
        drain_block();
        configure(4'd6, 8'hEF, 8'hFF, 64'd0, {16'd0, 16'd1, 16'd0, 16'd2});
        send_beat(CMD_TICK, 4'd0, 32'h0);
        send_beat(CMD_TICK, 4'd0, 32'h0);
        drain_block();
        configure(4'd8, 8'hFF, 8'h00, 64'd0, {16'd0, 16'd1, 16'd0, 16'd2});
        send_beat(CMD_TICK, 4'd0, 32'h0);
        drain_block();
    endtask

    task automatic test_backpressure();
        configure(4'd8, 8'hFF, 8'h00, short_pulses(), short_pulses());
        sender_gaps = 1'b0;
        hold_req = 1'b1;
        repeat (30) random_beat(30);
        sender_gaps = 1'b1;
        drain_block();
    endtask

    task automatic test_random();
        int items;
        int tick_pct;
        for (int phase = 0; phase < 8; phase++) begin
            items = 150;
            tick_pct = 35;
            case (phase)
                0: configure(4'd8, 8'hFF, 8'h00, short_pulses(), short_pulses());
                1: configure(4'd0, 8'hFF, 8'hFF, short_pulses(), short_pulses());
                2: configure(4'd15, 8'($urandom), 8'hFF, short_pulses(), short_pulses());
                3: configure(4'd3, 8'hFF, 8'($urandom), short_pulses(), short_pulses());
                4: configure(4'd8, 8'h00, 8'($urandom), short_pulses(), short_pulses());
                5: configure(4'($urandom_range(0, 15)), 8'($urandom), 8'($urandom),
                             {$urandom, $urandom}, {$urandom, $urandom});
                6: begin
                    configure(4'd8, 8'hFF, 8'h5A, 64'd0, 64'd0);
                    items = 400;
                    tick_pct = 85;
                end
                default: configure(4'($urandom_range(1, 8)), 8'($urandom), 8'($urandom),
                                   short_pulses(), short_pulses());
            endcase
            repeat (items) random_beat(tick_pct);
            drain_block();
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_disabled_expiry();
        test_backpressure();
        test_random();
        $display("Checked %0d result beats from %0d input beats over %0d register settings:",
                 results_checked, beats_sent, settings_applied);
        $display("  %0d ticks, %0d accepted commands, %0d pulse expiries, %0d mismatches",
                 ticks_sent, accepted_cmds, expiries, errors);
        if (errors == 0) begin
            $display("multi_relay_pulse_controller_test OK");
        end else begin
            $display("multi_relay_pulse_controller_test NOT OK");
        end
        $finish;
    end

endmodule

// File: multi_relay_pulse_controller.f
design/mrpc_pkg.sv
design/mrpc_relay.sv
design/multi_relay_pulse_controller.sv
dv/multi_relay_pulse_controller_test.sv
